>>> rtl/core/hglc_pkg.sv
// ----------------------------------------------------------------------------
// hglc_pkg
// Shared types, codes and helpers for the hashed group LRU cache.
// ----------------------------------------------------------------------------
package hglc_pkg;

    localparam int NUM_SETS_DEF  = 16;
    localparam int NUM_WAYS_DEF  = 4;
    localparam int MAX_BYTES_DEF = 8;

    localparam int KEY_W      = 32;
    localparam int BYTE_CNT_W = 4;
    localparam int DATA_W     = 64;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 64;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LEN_ERR   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // recency update applied to the set after the decision
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_ALLOC,
        UPD_PROMOTE,
        UPD_FLUSH
    } upd_mode_t;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [BYTE_CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < DATA_W / 8; i++)
        begin
            if (BYTE_CNT_W'(i) < n)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/core/hglc_set_hash.sv
// ----------------------------------------------------------------------------
// hglc_set_hash
// Remainder unit: set index = operand mod NUM_SETS by reciprocal multiply,
// with operand, product and remainder registers between start and done.
// ----------------------------------------------------------------------------
module hglc_set_hash #(
    parameter int NUM_SETS = hglc_pkg::NUM_SETS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hglc_pkg::KEY_W-1:0] operand,
    output logic                      done,
    output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] set_idx
);

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int KW     = hglc_pkg::KEY_W;
    localparam int SHIFT  = KW + $clog2(NUM_SETS);
    localparam int PROD_W = 2 * KW + 1;
    // ceil(2^SHIFT / NUM_SETS): gives the exact quotient for any KW-bit operand
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
    localparam logic [KW:0] RECIP = RECIP_FULL[KW:0];

    logic              p1_reg;
    logic              p2_reg;
    logic              done_reg;
    logic [KW-1:0]     opnd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SET_W-1:0]  rem_reg;
    logic [KW-1:0]     quo;
    logic [KW-1:0]     rem_full;

    assign quo      = KW'(prod_reg >> SHIFT);
    assign rem_full = opnd_reg - quo * KW'(NUM_SETS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg   <= 1'b0;
            p2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_reg   <= start;
            p2_reg   <= p1_reg;
            done_reg <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            opnd_reg <= operand;
        end
        if (p1_reg)
        begin
            prod_reg <= PROD_W'(opnd_reg) * PROD_W'(RECIP);
        end
        if (p2_reg)
        begin
            rem_reg <= rem_full[SET_W-1:0];
        end
    end

    assign done    = done_reg;
    assign set_idx = rem_reg;

endmodule

>>> rtl/core/hashed_group_lru_cache_top.sv
// ----------------------------------------------------------------------------
// hashed_group_lru_cache_top: set-associative cache with per-set LRU order.
// Each item passes the remainder unit, a scan of the set's ways and a decision;
// a second way scan updates recency when it changes, then the result is loaded.
// One item at a time: next accept in the cycle after the result is loaded; a
// held result stalls the input. Reset: a clear state zeroes valid/age of every entry.
// ----------------------------------------------------------------------------
module hashed_group_lru_cache_top #(
    parameter int NUM_SETS  = hglc_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = hglc_pkg::NUM_WAYS_DEF,
    parameter int MAX_BYTES = hglc_pkg::MAX_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // res_key[31:0], res_class[63:32], byte_count[67:64], write_data[131:68], zero
    input  logic [hglc_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [hglc_pkg::REQ_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[63:0]
    output logic [hglc_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [hglc_pkg::STAT_W-1:0]      m_tuser
);

    localparam int DEPTH = NUM_SETS * NUM_WAYS;
    localparam int ENT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CNT_W = $clog2(NUM_WAYS + 1);
    localparam int AGE_W = WAY_W;
    localparam int LEN_W = $clog2(MAX_BYTES + 1);
    localparam int PAY_W = 8 * MAX_BYTES;
    localparam int KW    = hglc_pkg::KEY_W;
    localparam int BW    = hglc_pkg::BYTE_CNT_W;
    localparam int DW    = hglc_pkg::DATA_W;

    // request fields latched at accept
    logic [hglc_pkg::REQ_W-1:0] req_reg;
    logic [KW-1:0]              key_reg;
    logic [KW-1:0]              cls_reg;
    logic [BW-1:0]              len_reg;
    logic [DW-1:0]              wd_reg;

    hglc_pkg::state_t state_reg, state_next;

    // memories: recency state (cleared at reset) and entry contents
    logic [AGE_W:0]  meta_mem [DEPTH];
    logic [KW-1:0]   key_mem  [DEPTH];
    logic [KW-1:0]   cls_mem  [DEPTH];
    logic [LEN_W-1:0] len_mem [DEPTH];
    logic [PAY_W-1:0] pay_mem [DEPTH];

    logic             valid_q_reg;
    logic [AGE_W-1:0] age_q_reg;
    logic [KW-1:0]    key_q_reg;
    logic [KW-1:0]    cls_q_reg;
    logic [LEN_W-1:0] len_q_reg;
    logic [PAY_W-1:0] pay_q_reg;

    logic [ENT_W-1:0] clr_cnt_reg;
    logic [ENT_W-1:0] base_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             rdv_reg;
    logic [WAY_W-1:0] rdway_reg;

    // scan results
    logic             hit_reg;
    logic [WAY_W-1:0] hit_way_reg;
    logic [AGE_W-1:0] hit_age_reg;
    logic [LEN_W-1:0] hit_len_reg;
    logic [PAY_W-1:0] hit_pay_reg;
    logic             free_found_reg;
    logic [WAY_W-1:0] free_way_reg;
    logic             maxv_found_reg;
    logic [AGE_W-1:0] max_age_reg;
    logic [WAY_W-1:0] max_way_reg;

    // decision results
    hglc_pkg::upd_mode_t mode_reg;
    logic [WAY_W-1:0]    tgt_way_reg;
    logic [AGE_W-1:0]    old_age_reg;
    logic [hglc_pkg::STAT_W-1:0] res_status_reg;
    logic [DW-1:0]       res_data_reg;

    logic                          out_valid_reg;
    logic [hglc_pkg::STAT_W-1:0]   out_status_reg;
    logic [DW-1:0]                 out_data_reg;

    // hash unit
    logic             hash_start;
    logic             hash_done;
    logic [SET_W-1:0] set_idx;

    // control strobes
    logic             rd_en;
    logic             scan_eval;
    logic             upd_eval;
    logic             scan_last;
    logic             dec_en;
    logic             out_load;
    logic [ENT_W-1:0] rd_addr;

    // decision logic
    logic [DW-1:0]               mask;
    logic [hglc_pkg::STAT_W-1:0] dec_status;
    logic [DW-1:0]               dec_rdata;
    hglc_pkg::upd_mode_t         dec_mode;
    logic [WAY_W-1:0]            dec_tgt;
    logic                        dec_data_we;
    logic [LEN_W-1:0]            dec_len;
    logic [PAY_W-1:0]            dec_pay;
    logic [ENT_W-1:0]            data_waddr;

    // per-way recency update
    logic             meta_we;
    logic [ENT_W-1:0] meta_waddr;
    logic             upd_valid;
    logic [AGE_W-1:0] upd_age;
    logic             is_tgt;

    hglc_set_hash #(
        .NUM_SETS (NUM_SETS)
    ) u_set_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .operand (s_tdata[KW-1:0] ^ s_tdata[2*KW-1:KW]),
        .done    (hash_done),
        .set_idx (set_idx)
    );

    assign scan_last = rdv_reg && (rdway_reg == WAY_W'(NUM_WAYS - 1));
    assign rd_addr   = base_reg + ENT_W'(cnt_reg[WAY_W-1:0]);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hglc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == ENT_W'(DEPTH - 1))
                begin
                    state_next = hglc_pkg::ST_IDLE;
                end
            end
            hglc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = hglc_pkg::ST_HASH;
                end
            end
            hglc_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = hglc_pkg::ST_SCAN;
                end
            end
            hglc_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = hglc_pkg::ST_DECIDE;
                end
            end
            hglc_pkg::ST_DECIDE:
            begin
                state_next = (dec_mode == hglc_pkg::UPD_NONE) ? hglc_pkg::ST_DONE
                                                              : hglc_pkg::ST_UPDATE;
            end
            hglc_pkg::ST_UPDATE:
            begin
                if (scan_last)
                begin
                    state_next = hglc_pkg::ST_DONE;
                end
            end
            hglc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = hglc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hglc_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        s_tready   = 1'b0;
        hash_start = 1'b0;
        rd_en      = 1'b0;
        scan_eval  = 1'b0;
        upd_eval   = 1'b0;
        dec_en     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            hglc_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                hash_start = s_tvalid;
            end
            hglc_pkg::ST_SCAN:
            begin
                rd_en     = (cnt_reg < CNT_W'(NUM_WAYS));
                scan_eval = rdv_reg;
            end
            hglc_pkg::ST_DECIDE:
            begin
                dec_en = 1'b1;
            end
            hglc_pkg::ST_UPDATE:
            begin
                rd_en    = (cnt_reg < CNT_W'(NUM_WAYS));
                upd_eval = rdv_reg;
            end
            hglc_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------- decision ----------------
    always_comb
    begin
        mask        = hglc_pkg::byte_mask(len_reg);
        dec_status  = hglc_pkg::STAT_OK;
        dec_rdata   = '0;
        dec_mode    = hglc_pkg::UPD_NONE;
        dec_tgt     = hit_way_reg;
        dec_data_we = 1'b0;
        dec_len     = hit_len_reg;
        dec_pay     = PAY_W'((DW'(hit_pay_reg) & ~mask) | (wd_reg & mask));
        case (req_reg)
            hglc_pkg::REQ_WRITE:
            begin
                if (len_reg > BW'(MAX_BYTES))
                begin
                    dec_status = hglc_pkg::STAT_LEN_ERR;
                end
                else if (hit_reg)
                begin
                    dec_data_we = 1'b1;
                    if (len_reg > BW'(hit_len_reg))
                    begin
                        dec_len = LEN_W'(len_reg);
                    end
                end
                else if (len_reg == '0)
                begin
                    dec_status = hglc_pkg::STAT_NO_SPACE;
                end
                else
                begin
                    // first free way, else evict the oldest
                    dec_tgt     = free_found_reg ? free_way_reg : max_way_reg;
                    dec_data_we = 1'b1;
                    dec_len     = LEN_W'(len_reg);
                    dec_pay     = PAY_W'(wd_reg & mask);
                    dec_mode    = hglc_pkg::UPD_ALLOC;
                end
            end
            hglc_pkg::REQ_READ:
            begin
                if (!hit_reg)
                begin
                    dec_status = hglc_pkg::STAT_NOT_FOUND;
                end
                else if (len_reg > BW'(hit_len_reg))
                begin
                    dec_status = hglc_pkg::STAT_LEN_ERR;
                end
                else if (len_reg != '0)
                begin
                    dec_rdata = DW'(hit_pay_reg) & mask;
                    dec_mode  = hglc_pkg::UPD_PROMOTE;
                end
            end
            hglc_pkg::REQ_FLUSH:
            begin
                if (hit_reg)
                begin
                    dec_mode = hglc_pkg::UPD_FLUSH;
                end
            end
            default:
            begin
                dec_status = hglc_pkg::STAT_OK;
            end
        endcase
    end

    assign data_waddr = base_reg + ENT_W'(dec_tgt);

    // ---------------- recency update for one way ----------------
    always_comb
    begin
        is_tgt    = (rdway_reg == tgt_way_reg);
        upd_valid = valid_q_reg;
        upd_age   = age_q_reg;
        case (mode_reg)
            hglc_pkg::UPD_ALLOC:
            begin
                if (is_tgt)
                begin
                    upd_valid = 1'b1;
                    upd_age   = '0;
                end
                else if (valid_q_reg)
                begin
                    upd_age = age_q_reg + AGE_W'(1);
                end
            end
            hglc_pkg::UPD_PROMOTE:
            begin
                if (is_tgt)
                begin
                    upd_age = '0;
                end
                else if (valid_q_reg && (age_q_reg < old_age_reg))
                begin
                    upd_age = age_q_reg + AGE_W'(1);
                end
            end
            hglc_pkg::UPD_FLUSH:
            begin
                if (is_tgt)
                begin
                    upd_valid = 1'b0;
                    upd_age   = '0;
                end
                else if (valid_q_reg && (age_q_reg > old_age_reg))
                begin
                    upd_age = age_q_reg - AGE_W'(1);
                end
            end
            default:
            begin
                upd_age = age_q_reg;
            end
        endcase
    end

    assign meta_we    = (state_reg == hglc_pkg::ST_CLEAR) || upd_eval;
    assign meta_waddr = (state_reg == hglc_pkg::ST_CLEAR) ? clr_cnt_reg
                                                          : base_reg + ENT_W'(rdway_reg);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hglc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            rdv_reg       <= 1'b0;
            mode_reg      <= hglc_pkg::UPD_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hglc_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ENT_W'(1);
            end
            if (hash_done || dec_en)
            begin
                cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            rdv_reg <= rd_en;
            if (dec_en)
            begin
                mode_reg <= dec_mode;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (hash_start)
        begin
            req_reg <= s_tuser;
            key_reg <= s_tdata[KW-1:0];
            cls_reg <= s_tdata[2*KW-1:KW];
            len_reg <= s_tdata[2*KW+BW-1:2*KW];
            wd_reg  <= s_tdata[2*KW+BW+DW-1:2*KW+BW];
        end
        if (hash_done)
        begin
            base_reg       <= ENT_W'(set_idx * NUM_WAYS);
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            maxv_found_reg <= 1'b0;
        end
        if (rd_en)
        begin
            rdway_reg <= cnt_reg[WAY_W-1:0];
        end
        if (scan_eval)
        begin
            if (valid_q_reg && (key_q_reg == key_reg) && (cls_q_reg == cls_reg) && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_way_reg <= rdway_reg;
                hit_age_reg <= age_q_reg;
                hit_len_reg <= len_q_reg;
                hit_pay_reg <= pay_q_reg;
            end
            if (!valid_q_reg && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_way_reg   <= rdway_reg;
            end
            if (valid_q_reg && (!maxv_found_reg || (age_q_reg > max_age_reg)))
            begin
                maxv_found_reg <= 1'b1;
                max_age_reg    <= age_q_reg;
                max_way_reg    <= rdway_reg;
            end
        end
        if (dec_en)
        begin
            tgt_way_reg    <= dec_tgt;
            old_age_reg    <= hit_age_reg;
            res_status_reg <= dec_status;
            res_data_reg   <= dec_rdata;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            {valid_q_reg, age_q_reg} <= meta_mem[rd_addr];
            key_q_reg <= key_mem[rd_addr];
            cls_q_reg <= cls_mem[rd_addr];
            len_q_reg <= len_mem[rd_addr];
            pay_q_reg <= pay_mem[rd_addr];
        end
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= (state_reg == hglc_pkg::ST_CLEAR) ? '0
                                                                      : {upd_valid, upd_age};
        end
        if (dec_en && dec_data_we)
        begin
            key_mem[data_waddr] <= key_reg;
            cls_mem[data_waddr] <= cls_reg;
            len_mem[data_waddr] <= dec_len;
            pay_mem[data_waddr] <= dec_pay;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // ---------------- assertions ----------------
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous one in flight");

    a_data_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != hglc_pkg::STAT_OK)) |-> (m_tdata == '0))
        else $error("nonzero read data with error status");

    a_age_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_eval && upd_valid) |-> (upd_age <= AGE_W'(NUM_WAYS - 1)))
        else $error("recency rank out of range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == hglc_pkg::ST_DONE) && out_valid_reg && !m_tready)
            |=> (state_reg == hglc_pkg::ST_DONE))
        else $error("result overwrote a pending output");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: hashed group LRU cache testbench
// Sends write, read and flush requests over the input stream. A cycle-free
// copy of the tag store, payload store and recency ranks predicts the status
// and read data of each reply. Replies are checked in order. Both sides idle
// at random outside a steady window, and the reply side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS    = hglc_pkg::NUM_SETS_DEF;
    localparam int WAYS    = hglc_pkg::NUM_WAYS_DEF;
    localparam int ENTRIES = SETS * WAYS;
    localparam int LATENCY = 2 * WAYS + 7;

    localparam logic [hglc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 425;
    localparam int IDLE_PCT     = 27;
    localparam int STEADY_FROM  = 200;
    localparam int STEADY_TO    = 300;
    localparam int HOLD_AT      = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [hglc_pkg::REQ_W-1:0]      kind;
        logic [hglc_pkg::KEY_W-1:0]      res_key;
        logic [hglc_pkg::KEY_W-1:0]      res_class;
        logic [hglc_pkg::BYTE_CNT_W-1:0] byte_count;
        logic [hglc_pkg::DATA_W-1:0]     write_data;
    } cache_req_t;

    typedef struct packed {
        logic [hglc_pkg::STAT_W-1:0] status;
        logic [hglc_pkg::DATA_W-1:0] read_data;
    } cache_reply_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hglc_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [hglc_pkg::REQ_W-1:0]      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [hglc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [hglc_pkg::STAT_W-1:0]     m_tuser;

    hashed_group_lru_cache_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow copy of the cache contents
    bit                            line_valid   [ENTRIES];
    bit [hglc_pkg::KEY_W-1:0]      line_key     [ENTRIES];
    bit [hglc_pkg::KEY_W-1:0]      line_class   [ENTRIES];
    bit [hglc_pkg::BYTE_CNT_W-1:0] line_length  [ENTRIES];
    bit [hglc_pkg::DATA_W-1:0]     line_payload [ENTRIES];
    bit [1:0]                      line_age     [ENTRIES];

    cache_req_t   request_queue[$];
    cache_reply_t expected_replies[$];
    cache_req_t   offered_req;

    int  items_accepted = 0;
    int  replies_seen = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    logic steady_window;

    assign steady_window = (items_accepted >= STEADY_FROM) && (items_accepted < STEADY_TO);

    function automatic logic [hglc_pkg::DATA_W-1:0] lane_mask(
        input logic [hglc_pkg::BYTE_CNT_W-1:0] n);
        if (n >= 8)
        begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // applies one request to the shadow cache and returns the reply it gives
    function automatic cache_reply_t predict_access(input cache_req_t r);
        cache_reply_t rep;
        int base;
        int hit;
        int slot;
        int e;
        int w;
        logic [hglc_pkg::DATA_W-1:0] m;
        bit [1:0] old_age;
        rep.status    = hglc_pkg::STAT_OK;
        rep.read_data = '0;
        base = int'((r.res_key ^ r.res_class) % SETS) * WAYS;
        hit  = -1;
        for (w = 0; w < WAYS; w++)
        begin
            if (hit < 0 && line_valid[base + w] && line_key[base + w] == r.res_key
                && line_class[base + w] == r.res_class)
            begin
                hit = w;
            end
        end
        m = lane_mask(r.byte_count);
        case (r.kind)
            hglc_pkg::REQ_WRITE:
            begin
                if (r.byte_count > hglc_pkg::MAX_BYTES_DEF)
                begin
                    rep.status = hglc_pkg::STAT_LEN_ERR;
                end
                else if (hit >= 0)
                begin
                    e = base + hit;
                    line_payload[e] = (line_payload[e] & ~m) | (r.write_data & m);
                    if (r.byte_count > line_length[e])
                    begin
                        line_length[e] = r.byte_count;
                    end
                end
                else if (r.byte_count == 0)
                begin
                    rep.status = hglc_pkg::STAT_NO_SPACE;
                end
                else
                begin
                    slot = -1;
                    for (w = 0; w < WAYS; w++)
                    begin
                        if (slot < 0 && !line_valid[base + w])
                        begin
                            slot = w;
                        end
                    end
                    // set full: evict the oldest way
                    if (slot < 0)
                    begin
                        slot = 0;
                        for (w = 1; w < WAYS; w++)
                        begin
                            if (line_age[base + w] > line_age[base + slot])
                            begin
                                slot = w;
                            end
                        end
                        line_valid[base + slot] = 1'b0;
                    end
                    for (w = 0; w < WAYS; w++)
                    begin
                        if (line_valid[base + w])
                        begin
                            line_age[base + w]++;
                        end
                    end
                    e = base + slot;
                    line_valid[e]   = 1'b1;
                    line_key[e]     = r.res_key;
                    line_class[e]   = r.res_class;
                    line_length[e]  = r.byte_count;
                    line_payload[e] = r.write_data & m;
                    line_age[e]     = 2'd0;
                end
            end
            hglc_pkg::REQ_READ:
            begin
                if (hit < 0)
                begin
                    rep.status = hglc_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    e = base + hit;
                    if (r.byte_count > line_length[e])
                    begin
                        rep.status = hglc_pkg::STAT_LEN_ERR;
                    end
                    else if (r.byte_count > 0)
                    begin
                        rep.read_data = line_payload[e] & m;
                        old_age = line_age[e];
                        for (w = 0; w < WAYS; w++)
                        begin
                            if (line_valid[base + w] && (base + w) != e
                                && line_age[base + w] < old_age)
                            begin
                                line_age[base + w]++;
                            end
                        end
                        line_age[e] = 2'd0;
                    end
                end
            end
            hglc_pkg::REQ_FLUSH:
            begin
                if (hit >= 0)
                begin
                    e = base + hit;
                    old_age = line_age[e];
                    line_valid[e] = 1'b0;
                    line_age[e]   = 2'd0;
                    for (w = 0; w < WAYS; w++)
                    begin
                        if (line_valid[base + w] && line_age[base + w] > old_age)
                        begin
                            line_age[base + w]--;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    task automatic add_request(input logic [hglc_pkg::REQ_W-1:0] kind,
                               input logic [hglc_pkg::KEY_W-1:0] key,
                               input logic [hglc_pkg::KEY_W-1:0] cls,
                               input logic [hglc_pkg::BYTE_CNT_W-1:0] len,
                               input logic [hglc_pkg::DATA_W-1:0] data);
        cache_req_t r;
        r.kind       = kind;
        r.res_key    = key;
        r.res_class  = cls;
        r.byte_count = len;
        r.write_data = data;
        request_queue.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sender: holds an offered item until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_replies.push_back(predict_access(offered_req));
                items_accepted <= items_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() != 0
                    && (steady_window || $urandom_range(99) >= IDLE_PCT))
                begin
                    offered_req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, offered_req.write_data, offered_req.byte_count,
                                 offered_req.res_class, offered_req.res_key};
                    s_tuser  <= offered_req.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long back-pressure stretch on the reply side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && replies_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= steady_window || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : reply_check
        cache_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            replies_seen <= replies_seen + 1;
            if (expected_replies.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("unexpected reply: status %0d data %h", m_tuser, m_tdata);
                end
                mismatches++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.status || m_tdata !== want.read_data)
                begin
                    if (mismatches < 10)
                    begin
                        $display("reply %0d: status exp %0d got %0d, data exp %h got %h",
                                 replies_seen, want.status, m_tuser, want.read_data, m_tdata);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit [hglc_pkg::KEY_W-1:0] pool_key   [16];
        bit [hglc_pkg::KEY_W-1:0] pool_class [16];
        int pool_set [3];
        int sent;
        int roll;
        int idx;
        logic [hglc_pkg::REQ_W-1:0]      kind;
        logic [hglc_pkg::KEY_W-1:0]      key;
        logic [hglc_pkg::KEY_W-1:0]      cls;
        logic [hglc_pkg::BYTE_CNT_W-1:0] len;

        // directed: all-ones tag, length errors, zero lengths, hit growth, flush,
        // unused request code, then eviction within set 0
        add_request(hglc_pkg::REQ_WRITE, '1, '1, 4'd8, '1);
        add_request(hglc_pkg::REQ_READ, '1, '1, 4'd8, '0);
        add_request(hglc_pkg::REQ_READ, '1, '1, 4'd9, '0);
        add_request(hglc_pkg::REQ_WRITE, '1, '1, 4'd9, 64'h0123_4567_89AB_CDEF);
        add_request(hglc_pkg::REQ_WRITE, 32'h1234_5678, 32'h9ABC_DEF0, 4'd15, '1);
        add_request(hglc_pkg::REQ_WRITE, '0, '0, 4'd0, 64'hDEAD_BEEF_CAFE_F00D);
        add_request(hglc_pkg::REQ_READ, '0, '0, 4'd1, '0);
        add_request(hglc_pkg::REQ_WRITE, '0, '0, 4'd2, 64'h1111_2222_3333_4455);
        add_request(hglc_pkg::REQ_WRITE, '0, '0, 4'd5, 64'hAAAA_BBBB_CCCC_DDEE);
        add_request(hglc_pkg::REQ_WRITE, '0, '0, 4'd0, '1);
        add_request(hglc_pkg::REQ_READ, '0, '0, 4'd6, '0);
        add_request(hglc_pkg::REQ_READ, '0, '0, 4'd5, '0);
        add_request(hglc_pkg::REQ_READ, '0, '0, 4'd0, '0);
        add_request(hglc_pkg::REQ_FLUSH, '0, '0, 4'd0, '0);
        add_request(hglc_pkg::REQ_FLUSH, '0, '0, 4'd0, '0);
        add_request(hglc_pkg::REQ_READ, '0, '0, 4'd1, '0);
        add_request(REQ_UNUSED, '1, '1, 4'd15, '1);
        add_request(hglc_pkg::REQ_WRITE, 32'd1, 32'd1, 4'd3, 64'h0000_0000_00A1_B2C3);
        add_request(hglc_pkg::REQ_WRITE, 32'd2, 32'd2, 4'd4, 64'h0000_0000_D4E5_F607);
        add_request(hglc_pkg::REQ_WRITE, 32'd3, 32'd3, 4'd8, 64'h8070_6050_4030_2010);
        add_request(hglc_pkg::REQ_READ, 32'd1, 32'd1, 4'd1, '0);
        add_request(hglc_pkg::REQ_WRITE, 32'd4, 32'd4, 4'd1, 64'hFF);
        add_request(hglc_pkg::REQ_WRITE, 32'd5, 32'd5, 4'd7, 64'h0102_0304_0506_0708);
        add_request(hglc_pkg::REQ_READ, '1, '1, 4'd8, '0);
        add_request(hglc_pkg::REQ_READ, 32'd2, 32'd2, 4'd4, '0);

        // small tag pool crowded into three sets so hits and evictions are common
        pool_set[0] = 0;
        pool_set[1] = 9;
        pool_set[2] = SETS - 1;
        for (int i = 0; i < 16; i++)
        begin
            pool_key[i]   = $urandom();
            pool_class[i] = ($urandom() & ~32'hF) | ((pool_key[i] ^ pool_set[i % 3]) & 32'hF);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 85)
            begin
                idx = $urandom_range(15);
                key = pool_key[idx];
                cls = pool_class[idx];
            end
            else
            begin
                key = $urandom();
                cls = $urandom();
            end
            roll = $urandom_range(99);
            if (roll < 42)
            begin
                kind = hglc_pkg::REQ_WRITE;
            end
            else if (roll < 80)
            begin
                kind = hglc_pkg::REQ_READ;
            end
            else if (roll < 97)
            begin
                kind = hglc_pkg::REQ_FLUSH;
            end
            else
            begin
                kind = REQ_UNUSED;
            end
            roll = $urandom_range(99);
            if (kind == hglc_pkg::REQ_READ)
            begin
                len = (roll < 60) ? 4'($urandom_range(1, 4))
                    : (roll < 90) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
            end
            else
            begin
                len = (roll < 80) ? 4'($urandom_range(1, 8))
                    : (roll < 90) ? 4'd0 : 4'($urandom_range(9, 15));
            end
            add_request(kind, key, cls, len, {$urandom(), $urandom()});
            sent++;
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);

        if (mismatches == 0 && expected_replies.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/hglc_pkg.sv
rtl/core/hglc_set_hash.sv
rtl/core/hashed_group_lru_cache_top.sv
bench/tb.sv
